>>> hw/rtl/nplt_pkg.sv
// ----------------------------------------------------------------------------
// nplt_pkg
// Shared types, codes and helpers for the neighbor port learning table.
// ----------------------------------------------------------------------------
package nplt_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_NUM_PORTS  = 2'd0;
  localparam logic [1:0] REG_READY_MASK = 2'd1;
  localparam logic [1:0] REG_UNASSIGNED = 2'd2;
  localparam logic [1:0] REG_BROADCAST  = 2'd3;

  localparam logic OP_LEARN  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NO_ROUTE = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [7:0] nbr_addr;
    logic [7:0] port_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] egress_port;
    logic [7:0] port_mask;
  } out_word_t;

  typedef struct packed {
    logic [3:0] num_ports;
    logic [7:0] port_ready_mask;
    logic [7:0] unassigned_addr;
    logic [7:0] broadcast_addr;
  } cfg_t;

  typedef struct packed {
    logic [7:0] addr;
    logic [2:0] port;
  } entry_t;

  // memory write request from the scanner
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
  } ram_wr_t;

  function automatic logic port_ready(cfg_t cfg, logic [7:0] p);
    logic ok;
    ok = (p < 8'd8) && (p < {4'b0, cfg.num_ports});
    return ok && cfg.port_ready_mask[p[2:0]];
  endfunction

  function automatic logic [7:0] ready_ports(cfg_t cfg);
    logic [7:0] m;
    m = '0;
    for (int p = 0; p < 8; p++) begin
      m[p] = port_ready(cfg, 8'(p));
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/nplt_cfg.sv
// ----------------------------------------------------------------------------
// nplt_cfg
// APB register block: port count, ready mask, unassigned and broadcast address.
// ----------------------------------------------------------------------------
module nplt_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nplt_pkg::PADDR_W-1:0] paddr,
  input  logic [nplt_pkg::PDATA_W-1:0] pwdata,
  output logic [nplt_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output nplt_pkg::cfg_t              cfg
);
  import nplt_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_ports       <= 4'd1;
      cfg.port_ready_mask <= 8'd1;
      cfg.unassigned_addr <= 8'd0;
      cfg.broadcast_addr  <= 8'hFF;
    end else if (wr) begin
      case (idx)
        REG_NUM_PORTS:  cfg.num_ports       <= pwdata[3:0];
        REG_READY_MASK: cfg.port_ready_mask <= pwdata[7:0];
        REG_UNASSIGNED: cfg.unassigned_addr <= pwdata[7:0];
        REG_BROADCAST:  cfg.broadcast_addr  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NUM_PORTS:  prdata = {28'd0, cfg.num_ports};
      REG_READY_MASK: prdata = {24'd0, cfg.port_ready_mask};
      REG_UNASSIGNED: prdata = {24'd0, cfg.unassigned_addr};
      REG_BROADCAST:  prdata = {24'd0, cfg.broadcast_addr};
      default:        prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/nplt_ram.sv
// ----------------------------------------------------------------------------
// nplt_ram
// Entry store: address and port per slot, one write and one registered read.
// ----------------------------------------------------------------------------
module nplt_ram (
  input  logic                        clk,
  input  nplt_pkg::ram_wr_t           wr,
  input  logic [nplt_pkg::IDX_W-1:0]  raddr,
  output nplt_pkg::entry_t            rdata
);
  import nplt_pkg::*;

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.waddr] <= wr.wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/nplt_scan.sv
// ----------------------------------------------------------------------------
// nplt_scan
// Item sequencer: checks, streams entries out of the store, decides, writes
// back and holds the result word until taken.
// ----------------------------------------------------------------------------
module nplt_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  nplt_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  nplt_pkg::in_word_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output nplt_pkg::out_word_t        out_data,
  output nplt_pkg::ram_wr_t          ram_wr,
  output logic [nplt_pkg::IDX_W-1:0] ram_raddr,
  input  nplt_pkg::entry_t           ram_rdata
);
  import nplt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]         state;
  in_word_t           item;
  out_word_t          res;
  logic [TABLE_ENTRIES-1:0] used;
  logic [IDX_W-1:0]   issue_idx;
  logic               issue_more;
  logic               data_vld;
  logic [IDX_W-1:0]   data_idx;
  logic               free_vld;
  logic [IDX_W-1:0]   free_idx;

  logic               cur_used;
  logic               hit;
  logic               last;
  logic               accept;
  logic               load_out;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign load_out  = (state == S_EMIT) && (!out_valid || out_ready);
  assign ram_raddr = issue_idx;

  assign cur_used = used[data_idx];
  assign hit      = cur_used && (ram_rdata.addr == item.nbr_addr);
  assign last     = (data_idx == LAST_IDX);

  // learn write-back, decided on the entry now coming out of the store
  always_comb begin
    ram_wr       = '0;
    ram_wr.wdata = '{addr: item.nbr_addr, port: item.port_id[2:0]};
    if (state == S_SCAN && data_vld && item.operation == OP_LEARN) begin
      if (hit) begin
        ram_wr.we    = 1'b1;
        ram_wr.waddr = data_idx;
      end else if (last && (free_vld || !cur_used)) begin
        ram_wr.we    = 1'b1;
        ram_wr.waddr = free_vld ? free_idx : data_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      out_valid  <= 1'b0;
      issue_more <= 1'b0;
      data_vld   <= 1'b0;
      free_vld   <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            item       <= in_data;
            issue_idx  <= '0;
            issue_more <= 1'b1;
            data_vld   <= 1'b0;
            free_vld   <= 1'b0;
            if (in_data.operation == OP_LEARN) begin
              if (in_data.nbr_addr == cfg.unassigned_addr ||
                  !port_ready(cfg, in_data.port_id)) begin
                res   <= '{status: ST_INVALID, egress_port: 3'd0, port_mask: 8'd0};
                state <= S_EMIT;
              end else begin
                state <= S_SCAN;
              end
            end else if (in_data.nbr_addr == cfg.broadcast_addr) begin
              res   <= '{status: ST_OK, egress_port: 3'd0, port_mask: ready_ports(cfg)};
              state <= S_EMIT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          data_vld <= issue_more;
          data_idx <= issue_idx;
          if (issue_more) begin
            if (issue_idx == LAST_IDX) begin
              issue_more <= 1'b0;
            end else begin
              issue_idx <= issue_idx + 1'b1;
            end
          end
          if (data_vld) begin
            if (item.operation == OP_LEARN) begin
              if (hit) begin
                res   <= '{status: ST_OK, egress_port: 3'd0, port_mask: 8'd0};
                state <= S_EMIT;
              end else if (last) begin
                if (free_vld || !cur_used) begin
                  used[free_vld ? free_idx : data_idx] <= 1'b1;
                  res <= '{status: ST_OK, egress_port: 3'd0, port_mask: 8'd0};
                end else begin
                  res <= '{status: ST_FULL, egress_port: 3'd0, port_mask: 8'd0};
                end
                state <= S_EMIT;
              end else if (!cur_used && !free_vld) begin
                free_vld <= 1'b1;
                free_idx <= data_idx;
              end
            end else begin
              if (hit && port_ready(cfg, {5'd0, ram_rdata.port})) begin
                res   <= '{status: ST_OK, egress_port: ram_rdata.port,
                           port_mask: 8'd1 << ram_rdata.port};
                state <= S_EMIT;
              end else if (last) begin
                res   <= '{status: ST_NO_ROUTE, egress_port: 3'd0, port_mask: 8'd0};
                state <= S_EMIT;
              end
            end
          end
        end
        S_EMIT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= res;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("took a new word right after accepting one");

  a_write_only_learn: assert property (@(posedge clk) disable iff (rst)
    ram_wr.we |-> (state == S_SCAN) && (item.operation == OP_LEARN))
    else $error("entry write outside a learn scan");

  a_write_ends_scan: assert property (@(posedge clk) disable iff (rst)
    ram_wr.we |=> state == S_EMIT)
    else $error("scan continued after write-back");

  a_learn_result_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && item.operation == OP_LEARN) |->
      (res.egress_port == 3'd0 && res.port_mask == 8'd0))
    else $error("learn result carries a port");

endmodule

>>> hw/rtl/neighbor_port_learning_table_core.sv
// ----------------------------------------------------------------------------
// neighbor_port_learning_table_core
// Learning table mapping neighbor addresses to egress ports.
// ----------------------------------------------------------------------------
// One word in, one word out. Items are handled one at a time: a learn or a
// unicast lookup streams the entry store through its single registered read
// port, one entry per cycle, and ends early on a hit (for a lookup, a hit on a
// ready port) or after the last slot; invalid learns and broadcast lookups
// skip the store. The result word turns valid in the same cycle that the block
// turns ready for the next word. A new word is taken while the previous result
// still waits on out_ready; its own result then waits, and holds off the input,
// until that word is taken.
// The used bits clear at reset, so no clearing pass is needed. Registers:
// 0x0 num_ports, 0x4 port_ready_mask, 0x8 unassigned_addr, 0xC broadcast_addr.
module neighbor_port_learning_table_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nplt_pkg::PADDR_W-1:0] paddr,
  input  logic [nplt_pkg::PDATA_W-1:0] pwdata,
  output logic [nplt_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  nplt_pkg::in_word_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output nplt_pkg::out_word_t          out_data
);
  import nplt_pkg::*;

  cfg_t             cfg;
  ram_wr_t          ram_wr;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  nplt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nplt_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nplt_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ram_wr    (ram_wr),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

>>> dv/tb_neighbor_port_learning_table_core.sv
// ----------------------------------------------------------------------------
// tb_neighbor_port_learning_table_core
// Self-checking bench for the neighbor port learning table. Learn and lookup
// words are driven over valid/ready, the registers over APB, and every result
// word is checked against an in-bench model of the table and its registers.
// ----------------------------------------------------------------------------
module tb_neighbor_port_learning_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  import nplt_pkg::*;

  localparam int DRAIN_CYCLES = 16;  // a bit above the worst-case scan time

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  in_word_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_word_t           out_data;

  neighbor_port_learning_table_core DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // model copy of the registers and the table
  logic [3:0] cfg_num_ports;
  logic [7:0] cfg_ready_mask;
  logic [7:0] cfg_unassigned;
  logic [7:0] cfg_broadcast;
  logic       tbl_used [TABLE_ENTRIES];
  logic [7:0] tbl_addr [TABLE_ENTRIES];
  logic [2:0] tbl_port [TABLE_ENTRIES];

  out_word_t  expected_routes [$];
  int         mismatch_count;
  int         send_idle_pct;
  int         rx_stall_pct;
  int         rx_hold_left;

  logic [7:0] addr_pool [12] = '{8'h05, 8'h00, 8'h10, 8'h20, 8'h30, 8'h40,
                                 8'h50, 8'h60, 8'h70, 8'h80, 8'hFF, 8'h01};

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic port_is_ready(logic [7:0] p);
    if (p >= 8'd8 || p >= {4'b0, cfg_num_ports}) return 1'b0;
    return cfg_ready_mask[p[2:0]];
  endfunction

  // expected result of one word; learns update the model table
  function automatic out_word_t predict_route(in_word_t w);
    out_word_t r;
    int        first_free;
    logic      hit;
    r = '0;
    hit = 1'b0;
    first_free = -1;
    if (w.operation == OP_LEARN) begin
      if (w.nbr_addr == cfg_unassigned || !port_is_ready(w.port_id)) begin
        r.status = ST_INVALID;
      end else begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!hit) begin
            if (!tbl_used[i]) begin
              if (first_free < 0) first_free = i;
            end else if (tbl_addr[i] == w.nbr_addr) begin
              tbl_port[i] = w.port_id[2:0];
              hit = 1'b1;
            end
          end
        end
        if (!hit) begin
          if (first_free < 0) begin
            r.status = ST_FULL;
          end else begin
            tbl_used[first_free] = 1'b1;
            tbl_addr[first_free] = w.nbr_addr;
            tbl_port[first_free] = w.port_id[2:0];
          end
        end
      end
    end else if (w.nbr_addr == cfg_broadcast) begin
      // broadcast never looks at the table
      for (int p = 0; p < 8; p++) r.port_mask[p] = port_is_ready(8'(p));
    end else begin
      r.status = ST_NO_ROUTE;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!hit && tbl_used[i] && tbl_addr[i] == w.nbr_addr &&
            port_is_ready({5'b0, tbl_port[i]})) begin
          r.status      = ST_OK;
          r.egress_port = tbl_port[i];
          r.port_mask   = 8'b1 << tbl_port[i];
          hit = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic in_word_t mk_word(logic op, logic [7:0] addr, logic [7:0] port);
    in_word_t w;
    w.operation = op;
    w.nbr_addr  = addr;
    w.port_id   = port;
    return w;
  endfunction

  // Ends at the accepting rising edge with valid still high; at the following
  // falling edge the next call drives its own word or drops valid; lower_input drops valid.
  task automatic send_word(input in_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    expected_routes.push_back(predict_route(w));
  endtask

  task automatic lower_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_all_results();
    lower_input();
    while (expected_routes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_NUM_PORTS:  cfg_num_ports  = val[3:0];
      REG_READY_MASK: cfg_ready_mask = val[7:0];
      REG_UNASSIGNED: cfg_unassigned = val[7:0];
      REG_BROADCAST:  cfg_broadcast  = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [3:0] count, input logic [7:0] mask,
                            input logic [7:0] unassigned, input logic [7:0] bcast);
    wait_all_results();
    write_reg(REG_NUM_PORTS,  32'(count));
    write_reg(REG_READY_MASK, 32'(mask));
    write_reg(REG_UNASSIGNED, 32'(unassigned));
    write_reg(REG_BROADCAST,  32'(bcast));
  endtask

  // receiver: random stalls plus an optional long hold counted here
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_routes.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", out_data));
      end else begin
        want = expected_routes.pop_front();
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_data.status, want.status));
        if (out_data.egress_port !== want.egress_port)
          report_mismatch($sformatf("egress_port %0d, want %0d",
                                    out_data.egress_port, want.egress_port));
        if (out_data.port_mask !== want.port_mask)
          report_mismatch($sformatf("port_mask %h, want %h",
                                    out_data.port_mask, want.port_mask));
      end
    end
  end

  // reset defaults: one ready port, unassigned 0, broadcast FF
  task automatic test_reset_config();
    send_word(mk_word(OP_LEARN,  8'h00, 8'h00));  // unassigned address
    send_word(mk_word(OP_LEARN,  8'h05, 8'h00));
    send_word(mk_word(OP_LEARN,  8'h06, 8'h01));  // port beyond count
    send_word(mk_word(OP_LOOKUP, 8'h05, 8'hFF));
    send_word(mk_word(OP_LOOKUP, 8'hFF, 8'h00));
    send_word(mk_word(OP_LEARN,  8'h07, 8'hFF));
  endtask

  task automatic test_fill_and_rebind();
    set_config(4'd8, 8'hFF, 8'hFF, 8'h00);
    send_word(mk_word(OP_LEARN, 8'h00, 8'h07));   // broadcast address is learnable
    for (int i = 1; i <= 6; i++)
      send_word(mk_word(OP_LEARN, 8'(i * 16), 8'(i)));
    send_word(mk_word(OP_LEARN,  8'h70, 8'h00));  // table full
    send_word(mk_word(OP_LEARN,  8'h05, 8'h03));  // rebind
    send_word(mk_word(OP_LEARN,  8'hFF, 8'h01));
    send_word(mk_word(OP_LOOKUP, 8'h00, 8'h00));
    send_word(mk_word(OP_LOOKUP, 8'h05, 8'h00));
  endtask

  task automatic test_stale_entry_and_port_range();
    set_config(4'd15, 8'hF7, 8'h00, 8'hFF);
    send_word(mk_word(OP_LOOKUP, 8'h05, 8'h00));  // bound to port 3, now not ready
    send_word(mk_word(OP_LEARN,  8'h05, 8'h08));
    send_word(mk_word(OP_LOOKUP, 8'hFF, 8'h00));
    send_word(mk_word(OP_LOOKUP, 8'h00, 8'h00));
  endtask

  task automatic test_no_ready_port();
    set_config(4'd0, 8'hFF, 8'h00, 8'hFF);
    send_word(mk_word(OP_LOOKUP, 8'hFF, 8'h00));
    send_word(mk_word(OP_LEARN,  8'h10, 8'h00));
    send_word(mk_word(OP_LOOKUP, 8'h10, 8'h00));
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    w.operation = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 70)      w.nbr_addr = addr_pool[$urandom_range(11)];
    else if (pick < 80) w.nbr_addr = cfg_broadcast;
    else if (pick < 85) w.nbr_addr = cfg_unassigned;
    else                w.nbr_addr = 8'($urandom_range(255));
    w.port_id = ($urandom_range(99) < 70) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
    return w;
  endfunction

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
    logic [3:0] count;
    logic [7:0] mask;
    count = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd8;
    if ($urandom_range(3) == 0) mask = 8'($urandom_range(255));
    else                        mask = 8'hFF & ~(8'($urandom_range(1)) << $urandom_range(7));
    set_config(count, mask, addr_pool[$urandom_range(11)], addr_pool[$urandom_range(11)]);
    send_idle_pct = idle_pct;
    rx_stall_pct  = stall_pct;
    repeat (n) send_word(random_word());
    wait_all_results();
    send_idle_pct = 0;
    rx_stall_pct  = 0;
  endtask

  // long receiver hold while the sender keeps pushing, then a full drain
  task automatic test_output_backpressure();
    set_config(4'd8, 8'hFF, 8'h00, 8'hFF);
    rx_hold_left = 300;
    repeat (40) send_word(random_word());
    wait_all_results();
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    in_data        = '0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    rx_stall_pct   = 0;
    rx_hold_left   = 0;
    cfg_num_ports  = 4'd1;
    cfg_ready_mask = 8'h01;
    cfg_unassigned = 8'h00;
    cfg_broadcast  = 8'hFF;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_used[i] = 1'b0;
      tbl_addr[i] = '0;
      tbl_port[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_config();
    test_fill_and_rebind();
    test_stale_entry_and_port_range();
    test_no_ready_port();
    test_random_traffic(0, 0, 240);
    test_random_traffic(60, 0, 240);
    test_random_traffic(0, 60, 240);
    test_random_traffic(20, 20, 240);
    test_output_backpressure();

    wait_all_results();
    if (mismatch_count == 0) begin
      $display("tb_neighbor_port_learning_table_core: PASS");
    end else begin
      $display("tb_neighbor_port_learning_table_core: FAIL");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_neighbor_port_learning_table_core: FAIL");
    $finish;
  end

endmodule
